// File: rtl/tts_pkg.sv
// Shared constants, item kinds and result type for the scrollback console writer.
package tts_pkg;

  localparam int VIEW_ROWS_DEF    = 25;
  localparam int VIEW_COLUMNS_DEF = 80;
  localparam int BUFFER_ROWS_DEF  = 256;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;

  typedef enum logic [2:0] {
    KIND_WRITE  = 3'd0,
    KIND_ANCHOR = 3'd1,
    KIND_VIEW   = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_READ   = 3'd4
  } tts_kind_e;

  typedef struct packed {
    logic       print_valid;
    logic [7:0] print_char;
    logic [4:0] print_row;
    logic [6:0] print_column;
    logic       redraw;
    logic [7:0] view_start;
    logic [7:0] read_data;
  } tts_result_t;

endpackage

// File: rtl/tts_store.sv
// Character store and per-row line length store, each with one write and one registered read port.
module tts_store import tts_pkg::*; #(
  parameter int BUFFER_ROWS  = BUFFER_ROWS_DEF,
  parameter int VIEW_COLUMNS = VIEW_COLUMNS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // write side, driven by the item being processed
  input  logic                                        text_we_i,
  input  logic [$clog2(BUFFER_ROWS*VIEW_COLUMNS)-1:0] text_waddr_i,
  input  logic [7:0]                                  text_wdata_i,
  input  logic                                        len_we_i,
  input  logic [$clog2(BUFFER_ROWS)-1:0]              len_waddr_i,
  input  logic [$clog2(VIEW_COLUMNS+1)-1:0]           len_wdata_i,
  // read side, issued when a new item is taken in
  input  logic                                        re_i,
  input  logic [$clog2(BUFFER_ROWS*VIEW_COLUMNS)-1:0] text_raddr_i,
  input  logic [$clog2(BUFFER_ROWS)-1:0]              len_raddr_i,
  output logic [7:0]                                  cell_o,
  output logic [$clog2(VIEW_COLUMNS+1)-1:0]           len_o
);

  localparam int CW    = $clog2(VIEW_COLUMNS + 1);
  localparam int CELLS = BUFFER_ROWS * VIEW_COLUMNS;

  logic [7:0]    text_mem [CELLS];
  logic [CW-1:0] len_mem  [BUFFER_ROWS];

  logic [7:0]    cell_q;
  logic [7:0]    cell_byp_q;
  logic          cell_hit_q;
  logic [CW-1:0] len_q;
  logic [CW-1:0] len_byp_q;
  logic          len_hit_q;

  // character store
  always_ff @(posedge clk_i) begin
    if (text_we_i) begin
      text_mem[text_waddr_i] <= text_wdata_i;
    end
    if (re_i) begin
      cell_q     <= text_mem[text_raddr_i];
      cell_byp_q <= text_wdata_i;
    end
  end

  // line length store
  always_ff @(posedge clk_i) begin
    if (len_we_i) begin
      len_mem[len_waddr_i] <= len_wdata_i;
    end
    if (re_i) begin
      len_q     <= len_mem[len_raddr_i];
      len_byp_q <= len_wdata_i;
    end
  end

  // note a write landing on the address read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_hit_q <= 1'b0;
      len_hit_q  <= 1'b0;
    end else if (re_i) begin
      cell_hit_q <= text_we_i && (text_waddr_i == text_raddr_i);
      len_hit_q  <= len_we_i && (len_waddr_i == len_raddr_i);
    end
  end

  assign cell_o = cell_hit_q ? cell_byp_q : cell_q;
  assign len_o  = len_hit_q ? len_byp_q : len_q;

endmodule

// File: rtl/tts_cursor.sv
// Cursor, view and anchor state with the per-item update and result logic.
module tts_cursor import tts_pkg::*; #(
  parameter int VIEW_ROWS    = VIEW_ROWS_DEF,
  parameter int VIEW_COLUMNS = VIEW_COLUMNS_DEF,
  parameter int BUFFER_ROWS  = BUFFER_ROWS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        fire_i,
  input  logic [2:0]                                  kind_i,
  input  logic [7:0]                                  char_i,
  input  logic [31:0]                                 value_i,
  input  logic [$clog2(BUFFER_ROWS)-1:0]              rd_row_i,
  input  logic [$clog2(VIEW_COLUMNS+1)-1:0]           rd_col_i,
  input  logic                                        rd_ok_i,
  input  logic [7:0]                                  cell_i,
  input  logic [$clog2(VIEW_COLUMNS+1)-1:0]           len_i,
  output tts_result_t                                 res_o,
  output logic                                        text_we_o,
  output logic [$clog2(BUFFER_ROWS*VIEW_COLUMNS)-1:0] text_waddr_o,
  output logic                                        len_we_o,
  output logic [$clog2(BUFFER_ROWS)-1:0]              len_waddr_o,
  output logic [$clog2(VIEW_COLUMNS+1)-1:0]           len_wdata_o
);

  localparam int RW = $clog2(BUFFER_ROWS);
  localparam int CW = $clog2(VIEW_COLUMNS + 1);
  localparam int AW = $clog2(BUFFER_ROWS * VIEW_COLUMNS);
  localparam int EW = RW + 8;

  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] view_q, view_d;
  logic          anch_q, anch_d;

  logic [RW-1:0] rel;
  logic [EW-1:0] rel_ext;
  logic          visible;
  logic [RW-1:0] view_inc;
  logic [RW:0]   row_inc;
  logic [RW:0]   row_n;
  logic [CW-1:0] col_inc;
  logic          col_wrap;
  logic [EW-1:0] row_ext;
  logic          partial;
  logic [EW-1:0] anch_view;
  logic          cell_ok;
  logic [EW-1:0] view_ext;
  logic [7:0]    col8;
  logic          text_we;
  logic          len_we;

  // distance of the cursor from the first shown row
  assign rel      = cur_row_q - view_q;
  assign rel_ext  = {{8{1'b0}}, rel};
  assign visible  = rel_ext < EW'(VIEW_ROWS);
  assign view_inc = view_q + RW'(1);
  assign row_inc  = {1'b0, cur_row_q} + (RW+1)'(1);
  assign col_inc  = cur_col_q + CW'(1);
  assign col_wrap = col_inc == CW'(VIEW_COLUMNS);
  assign col8     = 8'(cur_col_q);

  // view row chosen when anchoring
  assign row_ext  = {{8{1'b0}}, cur_row_q};
  assign partial  = cur_col_q != '0;
  always_comb begin
    if (row_ext < EW'(VIEW_ROWS)) begin
      anch_view = '0;
    end else if (row_ext == EW'(VIEW_ROWS)) begin
      anch_view = row_ext - EW'(partial);
    end else begin
      anch_view = row_ext - EW'(VIEW_ROWS) + EW'(partial);
    end
  end

  // a cell holds data only if the cursor has passed it since the last wipe
  assign cell_ok = rd_ok_i &&
                   (((rd_row_i < cur_row_q) && (rd_col_i < len_i)) ||
                    ((rd_row_i == cur_row_q) && (rd_col_i < cur_col_q)));

  // next state and result
  always_comb begin
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    view_d      = view_q;
    anch_d      = anch_q;
    row_n       = {1'b0, cur_row_q};
    text_we     = 1'b0;
    len_we      = 1'b0;
    len_wdata_o = cur_col_q;
    res_o       = '0;
    case (tts_kind_e'(kind_i))
      KIND_WRITE: begin
        if (!visible) begin
          if (anch_q) begin
            view_d = view_inc;
          end
          res_o.redraw = 1'b1;
        end
        if (char_i == NEWLINE_CHAR) begin
          cur_col_d = '0;
          row_n     = row_inc;
          len_we    = 1'b1;
        end else begin
          text_we = 1'b1;
          if (col_wrap) begin
            cur_col_d   = '0;
            row_n       = row_inc;
            len_we      = 1'b1;
            len_wdata_o = CW'(VIEW_COLUMNS);
          end else begin
            cur_col_d = col_inc;
          end
          if (visible) begin
            res_o.print_valid  = 1'b1;
            res_o.print_char   = char_i;
            res_o.print_row    = rel_ext[4:0];
            res_o.print_column = col8[6:0];
          end
        end
        // ran past the last row: wipe
        if (row_n[RW]) begin
          cur_row_d    = '0;
          cur_col_d    = '0;
          view_d       = '0;
          res_o.redraw = 1'b1;
        end else begin
          cur_row_d = row_n[RW-1:0];
        end
      end
      KIND_ANCHOR: begin
        anch_d = value_i == 32'd1;
        if (value_i == 32'd1) begin
          view_d = anch_view[RW-1:0];
        end
      end
      KIND_VIEW: begin
        view_d = value_i[RW-1:0];
      end
      KIND_CLEAR: begin
        cur_row_d = '0;
        cur_col_d = '0;
        view_d    = '0;
      end
      KIND_READ: begin
        if (cell_ok) begin
          res_o.read_data = cell_i;
        end
      end
      default: begin
      end
    endcase
    view_ext         = {{8{1'b0}}, view_d};
    res_o.view_start = view_ext[7:0];
  end

  assign text_we_o    = fire_i && text_we;
  assign text_waddr_o = AW'(cur_row_q) * AW'(VIEW_COLUMNS) + AW'(cur_col_q);
  assign len_we_o     = fire_i && len_we;
  assign len_waddr_o  = cur_row_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
      view_q    <= '0;
      anch_q    <= 1'b1;
    end else if (fire_i) begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      view_q    <= view_d;
      anch_q    <= anch_d;
    end
  end

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_col_q < CW'(VIEW_COLUMNS))
    else $error("cursor column beyond line end");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (kind_i == KIND_CLEAR) |=>
      (cur_row_q == '0) && (cur_col_q == '0) && (view_q == '0))
    else $error("clear left cursor or view behind");

  a_store_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_we_o |-> fire_i && (kind_i == KIND_WRITE) && (char_i != NEWLINE_CHAR))
    else $error("store written by a non-printing item");

  a_print_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.print_valid |-> (kind_i == KIND_WRITE) && (char_i != NEWLINE_CHAR))
    else $error("print reported for a wrong item");

endmodule

// File: rtl/text_terminal_scrollback_writer.sv
// Text console writer with scrollback: input register, store, cursor logic and result register.
// Each item passes through the input register, then the result register, and leaves the input
// register only when the result register is free or being emptied. Throughput: one item per cycle
// while out_ready_i takes the results. The store has one write and one read port, and a read that
// meets a write to the same cell in the same cycle takes the new data. Reset: cursor, view row and
// valid flags clear at once and the view is anchored. The store is not swept: a cell counts as
// written only once the cursor has passed it, so items are taken from the first cycle after reset.
module text_terminal_scrollback_writer import tts_pkg::*; #(
  parameter int VIEW_ROWS    = VIEW_ROWS_DEF,
  parameter int VIEW_COLUMNS = VIEW_COLUMNS_DEF,
  parameter int BUFFER_ROWS  = BUFFER_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  char_in_i,
  input  logic [31:0] value_i,
  input  logic [7:0]  read_row_i,
  input  logic [6:0]  read_column_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        print_valid_o,
  output logic [7:0]  print_char_o,
  output logic [4:0]  print_row_o,
  output logic [6:0]  print_column_o,
  output logic        redraw_o,
  output logic [7:0]  view_start_o,
  output logic [7:0]  read_data_o
);

  localparam int RW = $clog2(BUFFER_ROWS);
  localparam int CW = $clog2(VIEW_COLUMNS + 1);
  localparam int AW = $clog2(BUFFER_ROWS * VIEW_COLUMNS);
  localparam int EW = RW + 8;

  logic          s1_valid_q;
  logic [2:0]    s1_kind_q;
  logic [7:0]    s1_char_q;
  logic [31:0]   s1_value_q;
  logic [RW-1:0] s1_rrow_q;
  logic [CW-1:0] s1_rcol_q;
  logic          s1_rok_q;

  logic          out_valid_q;
  tts_result_t   res_q;
  tts_result_t   res;

  logic          in_xfer;
  logic          proc;
  logic [EW-1:0] rrow_ext;
  logic [7:0]    rcol_ext;
  logic          rd_ok;
  logic [AW-1:0] rd_addr;

  logic          text_we;
  logic [AW-1:0] text_waddr;
  logic          len_we;
  logic [RW-1:0] len_waddr;
  logic [CW-1:0] len_wdata;
  logic [7:0]    cell_rd;
  logic [CW-1:0] len_rd;

  // handshake: the held item moves on when the result register is free or being emptied
  assign proc       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || proc;
  assign in_xfer    = in_valid_i && in_ready_o;

  // read address for a cell read, issued on the input transfer
  assign rrow_ext = {{RW{1'b0}}, read_row_i};
  assign rcol_ext = {1'b0, read_column_i};
  assign rd_ok    = (rrow_ext < EW'(BUFFER_ROWS)) && (rcol_ext < 8'(VIEW_COLUMNS));
  assign rd_addr  = rd_ok ? (AW'(rrow_ext[RW-1:0]) * AW'(VIEW_COLUMNS) + AW'(rcol_ext[CW-1:0]))
                          : '0;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_kind_q  <= kind_i;
      s1_char_q  <= char_in_i;
      s1_value_q <= value_i;
      s1_rrow_q  <= rrow_ext[RW-1:0];
      s1_rcol_q  <= rcol_ext[CW-1:0];
      s1_rok_q   <= rd_ok;
    end
  end

  tts_store #(
    .BUFFER_ROWS  (BUFFER_ROWS),
    .VIEW_COLUMNS (VIEW_COLUMNS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_we_i    (text_we),
    .text_waddr_i (text_waddr),
    .text_wdata_i (s1_char_q),
    .len_we_i     (len_we),
    .len_waddr_i  (len_waddr),
    .len_wdata_i  (len_wdata),
    .re_i         (in_xfer),
    .text_raddr_i (rd_addr),
    .len_raddr_i  (rrow_ext[RW-1:0]),
    .cell_o       (cell_rd),
    .len_o        (len_rd)
  );

  tts_cursor #(
    .VIEW_ROWS    (VIEW_ROWS),
    .VIEW_COLUMNS (VIEW_COLUMNS),
    .BUFFER_ROWS  (BUFFER_ROWS)
  ) u_cursor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (proc),
    .kind_i       (s1_kind_q),
    .char_i       (s1_char_q),
    .value_i      (s1_value_q),
    .rd_row_i     (s1_rrow_q),
    .rd_col_i     (s1_rcol_q),
    .rd_ok_i      (s1_rok_q),
    .cell_i       (cell_rd),
    .len_i        (len_rd),
    .res_o        (res),
    .text_we_o    (text_we),
    .text_waddr_o (text_waddr),
    .len_we_o     (len_we),
    .len_waddr_o  (len_waddr),
    .len_wdata_o  (len_wdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign print_valid_o  = res_q.print_valid;
  assign print_char_o   = res_q.print_char;
  assign print_row_o    = res_q.print_row;
  assign print_column_o = res_q.print_column;
  assign redraw_o       = res_q.redraw;
  assign view_start_o   = res_q.view_start;
  assign read_data_o    = res_q.read_data;

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q)
    else $error("held item dropped while the result stalled");

  a_proc_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_q)
    else $error("processed item produced no result");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with an empty input register");

endmodule
